/* rtl/wfc_pkg.sv */
`default_nettype none
package wfc_pkg;
	localparam logic [1:0] CMD_LOAD = 2'd0;
	localparam logic [1:0] CMD_POSE = 2'd1;
	localparam logic [1:0] CMD_CANCEL = 2'd2;
	localparam logic [1:0] CMD_NONE = 2'd3;

	localparam logic [1:0] KIND_VEL = 2'd0;
	localparam logic [1:0] KIND_DONE = 2'd1;
	localparam logic [1:0] KIND_CANCEL = 2'd2;

	localparam logic [2:0] REG_MAX_LIN = 3'd0;
	localparam logic [2:0] REG_MAX_TURN = 3'd1;
	localparam logic [2:0] REG_LIN_GAIN = 3'd2;
	localparam logic [2:0] REG_ANG_GAIN = 3'd3;
	localparam logic [2:0] REG_RADIUS = 3'd4;
	localparam logic [2:0] REG_GATE = 3'd5;

	localparam int XW = 36;
	localparam int ZW = 24;
	localparam logic signed [ZW-1:0] PI_Q20 = 24'sd3294199;
	localparam logic signed [17:0] PI_Q13 = 18'sd25736;
	localparam logic signed [17:0] TWO_PI_Q13 = 18'sd51472;
	localparam logic [31:0] INV_GAIN = 32'h9B74EDA8;

	function automatic logic signed [ZW-1:0] atan_q20(input logic [4:0] i);
		case (i)
			5'd0: atan_q20 = 24'sd823550;
			5'd1: atan_q20 = 24'sd486170;
			5'd2: atan_q20 = 24'sd256879;
			5'd3: atan_q20 = 24'sd130396;
			5'd4: atan_q20 = 24'sd65451;
			5'd5: atan_q20 = 24'sd32757;
			5'd6: atan_q20 = 24'sd16383;
			5'd7: atan_q20 = 24'sd8192;
			5'd8: atan_q20 = 24'sd4096;
			5'd9: atan_q20 = 24'sd2048;
			5'd10: atan_q20 = 24'sd1024;
			5'd11: atan_q20 = 24'sd512;
			5'd12: atan_q20 = 24'sd256;
			5'd13: atan_q20 = 24'sd128;
			5'd14: atan_q20 = 24'sd64;
			5'd15: atan_q20 = 24'sd32;
			5'd16: atan_q20 = 24'sd16;
			5'd17: atan_q20 = 24'sd8;
			5'd18: atan_q20 = 24'sd4;
			5'd19: atan_q20 = 24'sd2;
			5'd20: atan_q20 = 24'sd1;
			default: atan_q20 = '0;
		endcase
	endfunction

	typedef struct packed {
		logic start;
		logic signed [32:0] dx;
		logic signed [32:0] dy;
	} cordic_req_t;

	typedef struct packed {
		logic done;
		logic [33:0] mag;
		logic signed [17:0] bearing;
	} cordic_rsp_t;
endpackage
`default_nettype wire

/* rtl/waypoint_follow_controller_unit.sv */
`default_nettype none
// Waypoint follower. Load beats (cmd 0) append a waypoint to an on-chip list
// (a load during a run restarts the list); one marked tlast starts the run at
// waypoint 0. Each pose beat (cmd 1) checks the current waypoint with a single
// iterative vectoring CORDIC, skipping waypoints already within arrive_radius,
// and returns one velocity command, or a complete beat after the last
// waypoint. Cancel (cmd 2) while running returns a canceled beat. A pose beat
// is accepted, then each waypoint examined takes a RAM read, a CORDIC start,
// CORDIC_STEPS micro-rotations, the gain multiply and acting on the result;
// then the result is multiplied, clamped and presented. The CORDIC does one
// micro-rotation a cycle.
// Input is not ready while a beat is in work or its result waits on the output.
// s_tdata: cmd[1:0], pos_x[33:2], pos_y[65:34], yaw[81:66], zero pad [87:82].
// s_tlast: last_point. m_tdata: linear_speed[14:0], turn_rate[30:15],
// target_x[62:31], target_y[94:63], target_index[102:95], pad to 104.
// m_tuser: kind.
module waypoint_follow_controller_unit #(
	parameter int MAX_WAYPOINTS = 256,
	parameter int CORDIC_STEPS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	input wire logic [87:0] s_tdata, // cmd, pos_x, pos_y, yaw
	input wire logic s_tlast,
	output logic m_tvalid,
	input wire logic m_tready,
	output logic [103:0] m_tdata, // linear_speed, turn_rate, target_x, target_y, target_index
	output logic [1:0] m_tuser, // kind
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [2:0] cfg_index,
	input wire logic [31:0] cfg_data
);
	localparam int AW = $clog2(MAX_WAYPOINTS);
	localparam int CW = $clog2(MAX_WAYPOINTS + 1);

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_READ = 7'b0000010,
		ST_CORD = 7'b0000100,
		ST_WAIT = 7'b0001000,
		ST_MUL = 7'b0010000,
		ST_CLAMP = 7'b0100000,
		ST_OUT = 7'b1000000
	} state_t;

	state_t st_q;
	logic [14:0] max_lin_q, max_turn_q, gate_q;
	logic [15:0] lin_gain_q, ang_gain_q;
	logic [30:0] radius_q;
	logic [CW-1:0] count_q, idx_q;
	logic running_q;
	logic signed [31:0] rx_q, ry_q;
	logic signed [15:0] yaw_q;
	logic [33:0] dist_q;
	logic signed [17:0] err_q;
	logic signed [34:0] turn_q;
	logic [50:0] lin_q;
	logic [14:0] o_lin_q;
	logic [15:0] o_turn_q;
	logic [31:0] o_x_q, o_y_q;
	logic [7:0] o_idx_q;
	logic [1:0] o_kind_q;

	logic [1:0] cmd;
	logic accept;
	logic [31:0] wx, wy;
	logic we;
	wfc_pkg::cordic_req_t creq;
	wfc_pkg::cordic_rsp_t crsp;
	logic signed [17:0] e0, e1;
	logic signed [17:0] abs_err;

	assign cmd = s_tdata[1:0];
	assign s_tready = (st_q == ST_IDLE) && !m_tvalid;
	assign accept = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign we = accept && cmd == wfc_pkg::CMD_LOAD && (running_q || count_q < CW'(MAX_WAYPOINTS));

	wfc_ram #(.WIDTH(32), .DEPTH(MAX_WAYPOINTS)) u_ram_x (
		.clk(clk), .we(we), .waddr(running_q ? AW'(0) : count_q[AW-1:0]),
		.wdata(s_tdata[33:2]), .raddr(idx_q[AW-1:0]), .rdata(wx));
	wfc_ram #(.WIDTH(32), .DEPTH(MAX_WAYPOINTS)) u_ram_y (
		.clk(clk), .we(we), .waddr(running_q ? AW'(0) : count_q[AW-1:0]),
		.wdata(s_tdata[65:34]), .raddr(idx_q[AW-1:0]), .rdata(wy));

	assign creq.start = (st_q == ST_CORD);
	assign creq.dx = 33'(signed'(wx)) - 33'(rx_q);
	assign creq.dy = 33'(signed'(wy)) - 33'(ry_q);

	wfc_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
		.clk(clk), .arst_n(arst_n), .req(creq), .rsp(crsp));

	// Wrap the heading error once into [-pi, pi].
	assign e0 = crsp.bearing - 18'(yaw_q);
	assign e1 = (e0 > wfc_pkg::PI_Q13) ? e0 - wfc_pkg::TWO_PI_Q13 :
		(e0 < -wfc_pkg::PI_Q13) ? e0 + wfc_pkg::TWO_PI_Q13 : e0;
	assign abs_err = err_q < 0 ? -err_q : err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_lin_q <= 15'd4096;
			max_turn_q <= 15'd4096;
			lin_gain_q <= 16'd3277;
			ang_gain_q <= 16'd4915;
			radius_q <= 31'd32768;
			gate_q <= 15'd1430;
		end else if (cfg_valid) begin
			case (cfg_index)
				wfc_pkg::REG_MAX_LIN: max_lin_q <= cfg_data[14:0];
				wfc_pkg::REG_MAX_TURN: max_turn_q <= cfg_data[14:0];
				wfc_pkg::REG_LIN_GAIN: lin_gain_q <= cfg_data[15:0];
				wfc_pkg::REG_ANG_GAIN: ang_gain_q <= cfg_data[15:0];
				wfc_pkg::REG_RADIUS: radius_q <= cfg_data[30:0];
				wfc_pkg::REG_GATE: gate_q <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			count_q <= '0;
			idx_q <= '0;
			running_q <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) m_tvalid <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (accept) begin
						rx_q <= s_tdata[33:2];
						ry_q <= s_tdata[65:34];
						yaw_q <= s_tdata[81:66];
						o_lin_q <= '0;
						o_turn_q <= '0;
						o_x_q <= '0;
						o_y_q <= '0;
						o_idx_q <= '0;
						case (cmd)
							wfc_pkg::CMD_LOAD: begin
								// restart the list if a run is in progress
								logic [CW-1:0] n;
								n = running_q ? CW'(1) :
									(count_q < CW'(MAX_WAYPOINTS) ? count_q + CW'(1) : count_q);
								count_q <= n;
								idx_q <= '0;
								running_q <= s_tlast && n != '0;
							end
							wfc_pkg::CMD_CANCEL: begin
								if (running_q) begin
									o_kind_q <= wfc_pkg::KIND_CANCEL;
									m_tvalid <= 1'b1;
								end
								count_q <= '0;
								idx_q <= '0;
								running_q <= 1'b0;
							end
							wfc_pkg::CMD_POSE: if (running_q) st_q <= ST_READ;
							default: ;
						endcase
					end
				end
				ST_READ: st_q <= ST_CORD; // ram read latency
				ST_CORD: st_q <= ST_WAIT;
				ST_WAIT: begin
					if (crsp.done) begin
						if (crsp.mag > 34'(radius_q)) begin
							dist_q <= crsp.mag;
							err_q <= e1;
							st_q <= ST_MUL;
						end else if (idx_q + CW'(1) >= count_q) begin
							o_kind_q <= wfc_pkg::KIND_DONE;
							m_tvalid <= 1'b1;
							count_q <= '0;
							idx_q <= '0;
							running_q <= 1'b0;
							st_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q + CW'(1);
							st_q <= ST_READ;
						end
					end
				end
				ST_MUL: begin
					turn_q <= 35'(err_q) * 35'(signed'({1'b0, ang_gain_q})) + 35'sd4096;
					lin_q <= (abs_err >= 18'(gate_q)) ? 51'd0 :
						51'(dist_q) * 51'(lin_gain_q) + 51'd32768;
					st_q <= ST_CLAMP;
				end
				ST_CLAMP: begin
					logic signed [34:0] t;
					logic signed [34:0] m;
					logic [34:0] l;
					m = 35'(signed'({1'b0, max_turn_q}));
					t = turn_q >>> 13;
					l = 35'(lin_q >> 16);
					if (t > m) t = m;
					if (t < -m) t = -m;
					if (l > 35'(max_lin_q)) l = 35'(max_lin_q);
					o_turn_q <= t[15:0];
					o_lin_q <= l[14:0];
					o_x_q <= wx;
					o_y_q <= wy;
					o_idx_q <= 8'(idx_q);
					o_kind_q <= wfc_pkg::KIND_VEL;
					st_q <= ST_OUT;
				end
				ST_OUT: begin
					m_tvalid <= 1'b1;
					st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tdata = {1'b0, o_idx_q, o_y_q, o_x_q, o_turn_q, o_lin_q};
	assign m_tuser = o_kind_q;
endmodule
`default_nettype wire

/* rtl/wfc_ram.sv */
`default_nettype none
module wfc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

/* rtl/wfc_cordic.sv */
`default_nettype none
// Iterative vectoring CORDIC: one micro-rotation per cycle, then a gain
// correction on one 34x16 multiplier, low half of the gain first, then the high half.
module wfc_cordic #(
	parameter int STEPS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire wfc_pkg::cordic_req_t req,
	output wfc_pkg::cordic_rsp_t rsp
);
	localparam int XW = wfc_pkg::XW;
	localparam int ZW = wfc_pkg::ZW;

	logic signed [XW-1:0] x_q, y_q;
	logic signed [ZW-1:0] z_q;
	logic [4:0] i_q;
	logic [1:0] ph_q; // 0 idle, 1 rotate, 2 gain lo, 3 gain hi
	logic [49:0] plo_q;
	logic [33:0] ux;
	logic signed [XW-1:0] xs, ys;
	logic signed [ZW-1:0] zr;
	logic [49:0] prod;
	logic [15:0] mk;

	assign ux = x_q[33:0];
	assign xs = x_q >>> i_q;
	assign ys = y_q >>> i_q;
	assign mk = (ph_q == 2'd2) ? wfc_pkg::INV_GAIN[15:0] : wfc_pkg::INV_GAIN[31:16];
	assign prod = {16'd0, ux} * {34'd0, mk};
	assign zr = z_q + ZW'(64);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= 2'd0;
			i_q <= '0;
			rsp.done <= 1'b0;
		end else begin
			rsp.done <= 1'b0;
			case (ph_q)
				2'd0: begin
					if (req.start) begin
						i_q <= '0;
						ph_q <= 2'd1;
						if (req.dx < 0) begin
							x_q <= -XW'(req.dx);
							y_q <= -XW'(req.dy);
							z_q <= (req.dy >= 0) ? wfc_pkg::PI_Q20 : -wfc_pkg::PI_Q20;
						end else begin
							x_q <= XW'(req.dx);
							y_q <= XW'(req.dy);
							z_q <= '0;
						end
					end
				end
				2'd1: begin
					if (y_q > 0) begin
						x_q <= x_q + ys;
						y_q <= y_q - xs;
						z_q <= z_q + wfc_pkg::atan_q20(i_q);
					end else begin
						x_q <= x_q - ys;
						y_q <= y_q + xs;
						z_q <= z_q - wfc_pkg::atan_q20(i_q);
					end
					i_q <= i_q + 5'd1;
					if (i_q == 5'(STEPS - 1)) ph_q <= 2'd2;
				end
				2'd2: begin
					plo_q <= prod >> 16;
					ph_q <= 2'd3;
				end
				2'd3: begin
					rsp.mag <= 34'((prod + plo_q) >> 16);
					rsp.bearing <= 18'(zr >>> 7);
					rsp.done <= 1'b1;
					ph_q <= 2'd0;
				end
				default: ph_q <= 2'd0;
			endcase
		end
	end
endmodule
`default_nettype wire

/* tb/waypoint_follow_controller_unit_tb.sv */
`timescale 1ns / 1ps
module waypoint_follow_controller_unit_tb;
	typedef struct {
		logic [1:0] cmd;
		logic [31:0] px;
		logic [31:0] py;
		logic [15:0] yaw;
		logic last;
		bit drain;
	} pose_cmd_t;

	typedef struct {
		logic [1:0] kind;
		logic [14:0] lin;
		logic [15:0] turn;
		logic [31:0] tx;
		logic [31:0] ty;
		logic [7:0] tidx;
	} vel_cmd_t;

	localparam longint ARC_PI = 3294199;
	localparam longint HALF_TURN = 25736;
	localparam longint FULL_TURN = 51472;
	localparam int LIST_DEPTH = 256;
	localparam longint ARC_TAB[16] = '{823550, 486170, 256879, 130396, 65451, 32757,
		16383, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [87:0] s_tdata = '0; // cmd, pos_x, pos_y, yaw, pad
	logic s_tlast = 1'b0; // last_point
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [103:0] m_tdata; // linear_speed, turn_rate, target_x, target_y, target_index, pad
	logic [1:0] m_tuser; // kind
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	waypoint_follow_controller_unit dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Controller shadow: settings, waypoint list and run state
	logic [14:0] cap_lin, cap_turn, gate;
	logic [15:0] gain_lin, gain_ang;
	logic [30:0] radius;
	logic [31:0] wp_x[LIST_DEPTH];
	logic [31:0] wp_y[LIST_DEPTH];
	int wp_count, goal;
	bit running;

	pose_cmd_t pending_cmds[$];
	vel_cmd_t pending_vel[$];
	pose_cmd_t on_bus;
	bit taken;
	bit calm;
	int n_queued, n_taken, n_results, n_vel, n_done, n_cancel, errors;

	// Vector (dx, dy) onto the x axis: distance Q16.16, bearing Q3.13
	function automatic void range_bearing(input longint dx, input longint dy,
			output longint unsigned rng, output longint brg);
		longint x, y, z, xs, ys;
		longint unsigned ux;
		x = dx;
		y = dy;
		z = 0;
		if (x < 0) begin
			z = (y >= 0) ? ARC_PI : -ARC_PI;
			x = -x;
			y = -y;
		end
		for (int i = 0; i < 16; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y > 0) begin
				x += ys; y -= xs; z += ARC_TAB[i];
			end else begin
				x -= ys; y += xs; z -= ARC_TAB[i];
			end
		end
		ux = x;
		rng = (ux * 64'h9B74 + ((ux * 64'hEDA8) >> 16)) >> 16;
		brg = (z + 64) >>> 7;
	endfunction

	task automatic predict_velocity(input pose_cmd_t c);
		vel_cmd_t r;
		longint rx, ry, brg, err, turn;
		longint unsigned rng, lin;
		int idx;
		r = '{default: '0};
		rng = 0;
		brg = 0;
		case (c.cmd)
			wfc_pkg::CMD_LOAD: begin
				// a load mid-run restarts the list with this point
				if (running) begin
					wp_count = 0; goal = 0; running = 0;
				end
				if (wp_count < LIST_DEPTH) begin
					wp_x[wp_count] = c.px;
					wp_y[wp_count] = c.py;
					wp_count++;
				end
				if (c.last && wp_count > 0) begin
					goal = 0; running = 1;
				end
			end
			wfc_pkg::CMD_CANCEL: begin
				if (running) begin
					r.kind = wfc_pkg::KIND_CANCEL;
					pending_vel = {pending_vel, r};
				end
				wp_count = 0; goal = 0; running = 0;
			end
			wfc_pkg::CMD_POSE: if (running) begin
				rx = longint'($signed(c.px));
				ry = longint'($signed(c.py));
				idx = goal;
				// skip every waypoint already inside the arrival radius
				while (idx < wp_count) begin
					range_bearing(longint'($signed(wp_x[idx])) - rx,
						longint'($signed(wp_y[idx])) - ry, rng, brg);
					if (rng > radius) break;
					idx++;
				end
				if (idx >= wp_count) begin
					r.kind = wfc_pkg::KIND_DONE;
					wp_count = 0; goal = 0; running = 0;
				end else begin
					goal = idx;
					err = brg - longint'($signed(c.yaw));
					if (err > HALF_TURN) err -= FULL_TURN;
					else if (err < -HALF_TURN) err += FULL_TURN;
					turn = (err * longint'(gain_ang) + 4096) >>> 13;
					if (turn > longint'(cap_turn)) turn = cap_turn;
					if (turn < -longint'(cap_turn)) turn = -longint'(cap_turn);
					if ((err < 0 ? -err : err) >= longint'(gate)) lin = 0;
					else lin = (rng * gain_lin + 32768) >> 16;
					if (lin > cap_lin) lin = cap_lin;
					r.kind = wfc_pkg::KIND_VEL;
					r.lin = lin[14:0];
					r.turn = turn[15:0];
					r.tx = wp_x[idx];
					r.ty = wp_y[idx];
					r.tidx = idx[7:0];
				end
				pending_vel = {pending_vel, r};
			end
			default: ;
		endcase
	endtask

	// Driver: present queued beats at the falling edge, hold until taken
	always @(negedge clk) begin
		if (arst_n && !(s_tvalid && !taken)) begin
			if (pending_cmds.size() > 0 && (calm || $urandom_range(99) >= 32)
					&& !(pending_cmds[0].drain && pending_vel.size() > 0)) begin
				on_bus = pending_cmds.pop_front();
				s_tdata <= {6'b0, on_bus.yaw, on_bus.py, on_bus.px, on_bus.cmd};
				s_tlast <= on_bus.last;
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
		taken = 0;
		m_tready <= arst_n && (calm || $urandom_range(99) >= 32);
	end

	// Monitor: take accepted input beats into the predictor, check result beats
	always @(posedge clk) begin
		vel_cmd_t want;
		if (s_tvalid && s_tready) begin
			taken = 1;
			n_taken++;
			predict_velocity(on_bus);
		end
		if (m_tvalid && m_tready) begin
			n_results++;
			if (pending_vel.size() == 0) begin
				$error("result beat with nothing pending: kind %0d", m_tuser);
				errors++;
			end else begin
				want = pending_vel.pop_front();
				case (want.kind)
					wfc_pkg::KIND_VEL: n_vel++;
					wfc_pkg::KIND_DONE: n_done++;
					default: n_cancel++;
				endcase
				if (m_tuser !== want.kind) begin
					$error("kind: expected %0d, got %0d", want.kind, m_tuser); errors++;
				end
				if (m_tdata[14:0] !== want.lin) begin
					$error("linear_speed: expected %0d, got %0d", want.lin, m_tdata[14:0]);
					errors++;
				end
				if (m_tdata[30:15] !== want.turn) begin
					$error("turn_rate: expected %0d, got %0d", $signed(want.turn),
						$signed(m_tdata[30:15]));
					errors++;
				end
				if (m_tdata[62:31] !== want.tx) begin
					$error("target_x: expected %h, got %h", want.tx, m_tdata[62:31]); errors++;
				end
				if (m_tdata[94:63] !== want.ty) begin
					$error("target_y: expected %h, got %h", want.ty, m_tdata[94:63]); errors++;
				end
				if (m_tdata[102:95] !== want.tidx) begin
					$error("target_index: expected %0d, got %0d", want.tidx, m_tdata[102:95]);
					errors++;
				end
			end
		end
	end

	task automatic queue_cmd(input logic [1:0] cmd, input logic [31:0] px, input logic [31:0] py,
			input logic [15:0] yaw, input logic last, input bit drain = 0);
		pose_cmd_t c;
		c = '{cmd, px, py, yaw, last, drain};
		pending_cmds = {pending_cmds, c};
		n_queued++;
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			wfc_pkg::REG_MAX_LIN: cap_lin = val[14:0];
			wfc_pkg::REG_MAX_TURN: cap_turn = val[14:0];
			wfc_pkg::REG_LIN_GAIN: gain_lin = val[15:0];
			wfc_pkg::REG_ANG_GAIN: gain_ang = val[15:0];
			wfc_pkg::REG_RADIUS: radius = val[30:0];
			default: gate = val[14:0];
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic write_all(input logic [31:0] a, b, c, d, e, f);
		write_reg(wfc_pkg::REG_MAX_LIN, a);
		write_reg(wfc_pkg::REG_MAX_TURN, b);
		write_reg(wfc_pkg::REG_LIN_GAIN, c);
		write_reg(wfc_pkg::REG_ANG_GAIN, d);
		write_reg(wfc_pkg::REG_RADIUS, e);
		write_reg(wfc_pkg::REG_GATE, f);
	endtask

	// Hold until every beat is taken and every result is back, then let
	// any result-free beat finish before touching the registers
	task automatic drain_all();
		wait (n_taken == n_queued && pending_vel.size() == 0);
		repeat (50) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_pos(input logic [31:0] base);
		if ($urandom_range(9) == 0) return $urandom;
		return base + 32'($signed($urandom_range(524288)) - 262144);
	endfunction

	function automatic logic [15:0] rand_yaw();
		return 16'($signed($urandom_range(2 * HALF_TURN)) - HALF_TURN);
	endfunction

	// Mostly well-formed runs: a short list, then pose beats walking along it
	task automatic queue_random(input int count);
		logic [31:0] bx, by, px, py;
		int n, m, start;
		start = n_queued;
		while (n_queued - start < count) begin
			if ($urandom_range(99) < 80) begin
				bx = ($urandom_range(3) == 0) ? $urandom : 32'($signed($urandom_range(4194304)) - 2097152);
				by = ($urandom_range(3) == 0) ? $urandom : 32'($signed($urandom_range(4194304)) - 2097152);
				n = $urandom_range(6, 1);
				for (int i = 0; i < n; i++)
					queue_cmd(wfc_pkg::CMD_LOAD, rand_pos(bx), rand_pos(by), 16'($urandom),
						i == n - 1);
				m = $urandom_range(12, 3);
				for (int i = 0; i < m; i++) begin
					px = rand_pos(bx);
					py = rand_pos(by);
					queue_cmd(wfc_pkg::CMD_POSE, px, py, rand_yaw(), 1'($urandom_range(1)));
				end
				if ($urandom_range(3) == 0)
					queue_cmd(wfc_pkg::CMD_CANCEL, $urandom, $urandom, 16'($urandom),
						1'($urandom_range(1)));
			end else begin
				queue_cmd(2'($urandom_range(3)), $urandom, $urandom,
					($urandom_range(1) ? rand_yaw() : 16'($urandom)), 1'($urandom_range(1)));
			end
		end
	endtask

	initial begin
		cap_lin = 4096; cap_turn = 4096; gain_lin = 3277; gain_ang = 4915;
		radius = 32768; gate = 1430;
		wp_count = 0; goal = 0; running = 0;
		calm = 0; errors = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: reset settings, field extremes and every command path
		queue_cmd(wfc_pkg::CMD_POSE, 0, 0, 0, 0);                         // pose while idle
		queue_cmd(wfc_pkg::CMD_LOAD, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0);
		queue_cmd(wfc_pkg::CMD_CANCEL, 0, 0, 0, 0);                       // drop a partial list
		queue_cmd(wfc_pkg::CMD_LOAD, 32'h0004_0000, 32'h0000_0000, 0, 0);
		queue_cmd(wfc_pkg::CMD_LOAD, 32'h8000_0000, 32'h8000_0000, 0, 0);
		queue_cmd(wfc_pkg::CMD_LOAD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 1);
		queue_cmd(wfc_pkg::CMD_POSE, 0, 0, 16'(HALF_TURN), 0);
		queue_cmd(wfc_pkg::CMD_POSE, 0, 0, 16'(-HALF_TURN), 0);
		queue_cmd(wfc_pkg::CMD_POSE, 32'h0004_0000, 0, 0, 0);             // arrive, move on
		queue_cmd(wfc_pkg::CMD_POSE, 32'h7FFF_FFFF, 32'h8000_0000, 16'(HALF_TURN), 1);
		queue_cmd(wfc_pkg::CMD_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1); // unused code
		queue_cmd(wfc_pkg::CMD_POSE, 32'h8000_0000, 32'h7FFF_FFFF, 16'(-HALF_TURN), 0);
		queue_cmd(wfc_pkg::CMD_LOAD, 32'h0001_0000, 32'h0001_0000, 0, 1); // load mid-run
		queue_cmd(wfc_pkg::CMD_POSE, 0, 0, 16'd6434, 0, 1);               // on-heading, drain
		queue_cmd(wfc_pkg::CMD_POSE, 32'h0001_0000, 32'h0001_0000, 0, 0); // last reached
		queue_cmd(wfc_pkg::CMD_LOAD, 32'hFFFF_0000, 32'h0002_0000, 0, 1);
		queue_cmd(wfc_pkg::CMD_POSE, 32'h0000_8000, 32'hFFFF_8000, 16'd100, 0);
		queue_cmd(wfc_pkg::CMD_CANCEL, 0, 0, 0, 1);                       // cancel while running
		queue_cmd(wfc_pkg::CMD_CANCEL, 0, 0, 0, 0);
		drain_all();

		// Full list: every stop on the robot, then one point past the end
		for (int i = 0; i < LIST_DEPTH; i++)
			queue_cmd(wfc_pkg::CMD_LOAD, 32'h0010_0000, 32'hFFF0_0000, 0, 0);
		queue_cmd(wfc_pkg::CMD_LOAD, 32'h1234_5678, 32'h0765_4321, 0, 1); // dropped, still starts
		queue_cmd(wfc_pkg::CMD_POSE, 32'h0030_0000, 32'hFFF0_0000, 16'd0, 0);
		queue_cmd(wfc_pkg::CMD_POSE, 32'h0010_0000, 32'hFFF0_0000, 16'd0, 0);
		drain_all();

		// Settings sweep: largest, smallest, random, largest with a small radius, back to reset values
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: write_all(32767, 32767, 65535, 65535, 32'h7FFF_FFFF, 32'(HALF_TURN));
				1: write_all(0, 0, 0, 0, 0, 0);
				2: write_all($urandom_range(32767), $urandom_range(32767), $urandom_range(65535),
					$urandom_range(65535), $urandom_range(65536), $urandom_range(HALF_TURN));
				3: write_all(32767, 32767, 65535, 65535, 16384, 32'(HALF_TURN));
				default: write_all(4096, 4096, 3277, 4915, 32768, 1430);
			endcase
			calm = (ph == 3);
			queue_random(150);
			drain_all();
		end
		calm = 0;

		$display("Covered %0d input beats at reset values and five register sets, full list too;",
			n_taken);
		$display("%0d result beats: %0d velocity, %0d complete, %0d canceled.",
			n_results, n_vel, n_done, n_cancel);
		if (errors == 0 && pending_vel.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		#40_000_000;
		$display("FAILURE");
		$finish;
	end
endmodule
